[rtl/dsf2d_pkg.sv]
// Shared types and fixed widths for the damped 2D spring force pipeline.
package dsf2d_pkg;

    // Fixed field widths of the stream payload
    localparam int POS_W      = 32;
    localparam int COEF_W     = 31;
    localparam int DIFF_W     = POS_W + 1;
    localparam int IN_DATA_W  = 352;
    localparam int OUT_DATA_W = 128;
    localparam int OUT_USER_W = 2;

    // Square root: 66-bit radicand, 33-bit root, one root bit per stage
    localparam int RAD_W  = 2 * DIFF_W;
    localparam int ROOT_W = DIFF_W;
    localparam int REM_W  = ROOT_W + 2;

    // tuser bit positions on the result side
    localparam int USER_ZERO = 0;
    localparam int USER_SAT  = 1;

    // Clip bounds
    localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] NEG_MAX = 32'h8000_0000;

    // Per-spring values carried alongside the root and divide pipelines
    typedef struct packed {
        logic                     towards;
        logic                     zero;
        logic                     dx_neg;
        logic                     dy_neg;
        logic [DIFF_W-1:0]        dx_mag;
        logic [DIFF_W-1:0]        dy_mag;
        logic signed [DIFF_W-1:0] rvx;
        logic signed [DIFF_W-1:0] rvy;
        logic [COEF_W-1:0]        rest;
        logic [COEF_W-1:0]        kk;
        logic [COEF_W-1:0]        dd;
    } side_t;

endpackage

[rtl/damped_spring_force_2d.sv]
// Damped 2D spring force: fully pipelined Hooke's law with velocity damping.
//
// One spring request per clock is accepted and one result leaves per clock
// while no result is held on the output. Each request passes in turn through
// the registers that form and square the separation, the bit-per-stage square
// root, the two parallel restoring dividers that build the unit vector, and
// the multiply, shift and clip stages. The whole pipeline stalls together
// while a finished result is held on the output and not taken, so nothing
// is dropped or repeated.
// Coincident end points give zero forces with zero_separation set; clipped
// components raise saturated.
module damped_spring_force_2d #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pos_a_x, pos_a_y, vel_a_x, vel_a_y, pos_b_x, pos_b_y, vel_b_x, vel_b_y,
    // rest_length, stiffness, damping_coef, zero pad
    input  logic [dsf2d_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // action
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // force_a_x, force_a_y, force_b_x, force_b_y
    output logic [dsf2d_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // zero_separation, saturated
    output logic [dsf2d_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import dsf2d_pkg::*;

    localparam int SQ_N    = ROOT_W;
    localparam int DV_N    = FRAC_BITS + 1;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int UX_W    = FRAC_BITS + 2;
    localparam int PX_W    = DIFF_W + UX_W;
    localparam int PS_W    = PX_W + 1;
    localparam int PROJ_W  = PS_W - FRAC_BITS;
    localparam int LD_W    = ROOT_W + 1;
    localparam int EK_W    = LD_W + COEF_W + 1;
    localparam int EKF_W   = EK_W - FRAC_BITS;
    localparam int PD_W    = PROJ_W + COEF_W + 1;
    localparam int PDF_W   = PD_W - FRAC_BITS;
    localparam int S_W     = PDF_W + 1;
    localparam int FA_W    = UX_W + S_W;
    localparam int FAF_W   = FA_W - FRAC_BITS;
    localparam int FB_W    = FAF_W + 1;

    // Global advance: the output register is free or being emptied
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- Stage 0: differences and magnitudes ----------------
    logic signed [POS_W-1:0]  pax, pay, vax, vay, pbx, pby, vbx, vby;
    logic signed [DIFF_W-1:0] dx, dy, vbx_e, vby_e;
    side_t                    in_side;

    assign pax = s_axis_tdata[31:0];
    assign pay = s_axis_tdata[63:32];
    assign vax = s_axis_tdata[95:64];
    assign vay = s_axis_tdata[127:96];
    assign pbx = s_axis_tdata[159:128];
    assign pby = s_axis_tdata[191:160];
    assign vbx = s_axis_tdata[223:192];
    assign vby = s_axis_tdata[255:224];

    always_comb
    begin
        dx    = DIFF_W'(pax) - DIFF_W'(pbx);
        dy    = DIFF_W'(pay) - DIFF_W'(pby);
        vbx_e = s_axis_tuser ? '0 : DIFF_W'(vbx);
        vby_e = s_axis_tuser ? '0 : DIFF_W'(vby);
        in_side.towards = s_axis_tuser;
        in_side.zero    = (dx == '0) && (dy == '0);
        in_side.dx_neg  = dx[DIFF_W-1];
        in_side.dy_neg  = dy[DIFF_W-1];
        in_side.dx_mag  = dx[DIFF_W-1] ? -dx : dx;
        in_side.dy_mag  = dy[DIFF_W-1] ? -dy : dy;
        in_side.rvx     = DIFF_W'(vax) - vbx_e;
        in_side.rvy     = DIFF_W'(vay) - vby_e;
        in_side.rest    = s_axis_tdata[286:256];
        in_side.kk      = s_axis_tdata[317:287];
        in_side.dd      = s_axis_tdata[348:318];
    end

    side_t            s0_side_reg;
    logic             s0_vld_reg;
    side_t            s1_side_reg;
    logic             s1_vld_reg;
    logic [RAD_W-1:0] s1_sqx_reg, s1_sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg <= s_axis_tvalid;
            s1_vld_reg <= s0_vld_reg;
        end
    end

    // Stage 0 and 1 payload: register inputs, then square the separations
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_side_reg <= in_side;
            s1_side_reg <= s0_side_reg;
            s1_sqx_reg  <= RAD_W'(s0_side_reg.dx_mag) * RAD_W'(s0_side_reg.dx_mag);
            s1_sqy_reg  <= RAD_W'(s0_side_reg.dy_mag) * RAD_W'(s0_side_reg.dy_mag);
        end
    end

    // ---------------- Square root, one root bit per stage ----------------
    logic [RAD_W-1:0]  sq_rad_reg  [0:SQ_N];
    logic [REM_W-1:0]  sq_rem_reg  [0:SQ_N];
    logic [ROOT_W-1:0] sq_root_reg [0:SQ_N];
    side_t             sq_side_reg [0:SQ_N];
    logic              sq_vld_reg  [0:SQ_N];

    // Entry: radicand is the sum of squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else if (en)
            sq_vld_reg[0] <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rad_reg[0]  <= s1_sqx_reg + s1_sqy_reg;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_side_reg[0] <= s1_side_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < SQ_N; k++)
        begin : g_sqrt
            logic [REM_W+1:0] cat;
            logic [REM_W+1:0] trial;
            logic             take;

            always_comb
            begin
                cat   = {sq_rem_reg[k], sq_rad_reg[k][RAD_W-1 -: 2]};
                trial = {2'b00, sq_root_reg[k], 2'b01};
                take  = (cat >= trial);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sq_vld_reg[k+1] <= 1'b0;
                else if (en)
                    sq_vld_reg[k+1] <= sq_vld_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rad_reg[k+1]  <= {sq_rad_reg[k][RAD_W-3:0], 2'b00};
                    sq_rem_reg[k+1]  <= take ? REM_W'(cat - trial) : cat[REM_W-1:0];
                    sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], take};
                    sq_side_reg[k+1] <= sq_side_reg[k];
                end
            end
        end
    endgenerate

    // ---------------- Unit vector: two restoring dividers ----------------
    logic [ROOT_W-1:0] dv_len_reg  [0:DV_N];
    logic [ROOT_W-1:0] dv_remx_reg [0:DV_N];
    logic [ROOT_W-1:0] dv_remy_reg [0:DV_N];
    logic [Q_W-1:0]    dv_qx_reg   [0:DV_N];
    logic [Q_W-1:0]    dv_qy_reg   [0:DV_N];
    side_t             dv_side_reg [0:DV_N];
    logic              dv_vld_reg  [0:DV_N];

    // Entry: partial remainders start from the magnitudes less their low bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (en)
            dv_vld_reg[0] <= sq_vld_reg[SQ_N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_len_reg[0]  <= sq_root_reg[SQ_N];
            dv_remx_reg[0] <= sq_side_reg[SQ_N].dx_mag >> 1;
            dv_remy_reg[0] <= sq_side_reg[SQ_N].dy_mag >> 1;
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
            dv_side_reg[0] <= sq_side_reg[SQ_N];
        end
    end

    genvar j;
    generate
        for (j = 0; j < DV_N; j++)
        begin : g_div
            logic [ROOT_W:0] catx, caty, lenw;
            logic            bx, by, takex, takey;

            always_comb
            begin
                bx    = (j == 0) ? dv_side_reg[j].dx_mag[0] : 1'b0;
                by    = (j == 0) ? dv_side_reg[j].dy_mag[0] : 1'b0;
                catx  = {dv_remx_reg[j], bx};
                caty  = {dv_remy_reg[j], by};
                lenw  = {1'b0, dv_len_reg[j]};
                takex = (catx >= lenw);
                takey = (caty >= lenw);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_vld_reg[j+1] <= 1'b0;
                else if (en)
                    dv_vld_reg[j+1] <= dv_vld_reg[j];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_remx_reg[j+1] <= takex ? ROOT_W'(catx - lenw) : catx[ROOT_W-1:0];
                    dv_remy_reg[j+1] <= takey ? ROOT_W'(caty - lenw) : caty[ROOT_W-1:0];
                    dv_qx_reg[j+1]   <= {dv_qx_reg[j][Q_W-2:0], takex};
                    dv_qy_reg[j+1]   <= {dv_qy_reg[j][Q_W-2:0], takey};
                    dv_len_reg[j+1]  <= dv_len_reg[j];
                    dv_side_reg[j+1] <= dv_side_reg[j];
                end
            end
        end
    endgenerate

    // ---------------- Force arithmetic ----------------
    side_t                    dv_out;
    logic signed [UX_W-1:0]   ux, uy;
    logic signed [LD_W-1:0]   len_diff;
    logic signed [COEF_W:0]   kk_s;

    // Signed unit vector and length error
    always_comb
    begin
        dv_out   = dv_side_reg[DV_N];
        ux       = dv_out.dx_neg ? -$signed({1'b0, dv_qx_reg[DV_N]})
                                 : $signed({1'b0, dv_qx_reg[DV_N]});
        uy       = dv_out.dy_neg ? -$signed({1'b0, dv_qy_reg[DV_N]})
                                 : $signed({1'b0, dv_qy_reg[DV_N]});
        len_diff = $signed({3'b000, dv_out.rest}) - $signed({1'b0, dv_len_reg[DV_N]});
        kk_s     = $signed({1'b0, dv_out.kk});
    end

    logic signed [PX_W-1:0]  p1_px_reg, p1_py_reg;
    logic signed [EK_W-1:0]  p1_ek_reg;
    logic signed [UX_W-1:0]  p1_ux_reg, p1_uy_reg, p2_ux_reg, p2_uy_reg;
    logic signed [UX_W-1:0]  p3_ux_reg, p3_uy_reg, p4_ux_reg, p4_uy_reg;
    logic [COEF_W-1:0]       p1_dd_reg, p2_dd_reg;
    logic signed [PROJ_W-1:0] p2_proj_reg;
    logic signed [EKF_W-1:0] p2_ekf_reg, p3_ekf_reg;
    logic signed [PD_W-1:0]  p3_pd_reg;
    logic signed [S_W-1:0]   p4_s_reg;
    logic signed [FA_W-1:0]  p5_fax_reg, p5_fay_reg;
    logic [4:0]              p_tw_reg, p_zero_reg, p_vld_reg;

    logic signed [PS_W-1:0]  psum;
    logic signed [PDF_W-1:0] pdf;
    logic signed [PD_W-1:0]  pd_next;
    logic signed [S_W-1:0]   s_next;

    always_comb
    begin
        psum    = PS_W'(p1_px_reg) + PS_W'(p1_py_reg);
        pd_next = PD_W'(p2_proj_reg) * PD_W'($signed({1'b0, p2_dd_reg}));
        pdf     = p3_pd_reg[PD_W-1:FRAC_BITS];
        s_next  = S_W'(p3_ekf_reg) - S_W'(pdf);
    end

    // Valid and mode flags through the arithmetic stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= '0;
        else if (en)
            p_vld_reg <= {p_vld_reg[3:0], dv_vld_reg[DV_N]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_tw_reg   <= {p_tw_reg[3:0], dv_out.towards};
            p_zero_reg <= {p_zero_reg[3:0], dv_out.zero};
            // velocity projection products and stiffness term
            p1_px_reg  <= PX_W'(dv_out.rvx) * PX_W'(ux);
            p1_py_reg  <= PX_W'(dv_out.rvy) * PX_W'(uy);
            p1_ek_reg  <= EK_W'(len_diff) * EK_W'(kk_s);
            p1_ux_reg  <= ux;
            p1_uy_reg  <= uy;
            p1_dd_reg  <= dv_out.dd;
            // floor shifts
            p2_proj_reg <= psum[PS_W-1:FRAC_BITS];
            p2_ekf_reg  <= p1_ek_reg[EK_W-1:FRAC_BITS];
            p2_ux_reg   <= p1_ux_reg;
            p2_uy_reg   <= p1_uy_reg;
            p2_dd_reg   <= p1_dd_reg;
            // damping product
            p3_pd_reg   <= pd_next;
            p3_ekf_reg  <= p2_ekf_reg;
            p3_ux_reg   <= p2_ux_reg;
            p3_uy_reg   <= p2_uy_reg;
            // force magnitude along the unit vector
            p4_s_reg    <= s_next;
            p4_ux_reg   <= p3_ux_reg;
            p4_uy_reg   <= p3_uy_reg;
            // force components
            p5_fax_reg  <= FA_W'(p4_ux_reg) * FA_W'(p4_s_reg);
            p5_fay_reg  <= FA_W'(p4_uy_reg) * FA_W'(p4_s_reg);
        end
    end

    // ---------------- Clip and output register ----------------
    logic signed [FAF_W-1:0] fax, fay;
    logic signed [FB_W-1:0]  fbx, fby;
    logic [POS_W-1:0]        cax, cay, cbx, cby;
    logic                    sax, say, sbx, sby;
    logic [OUT_DATA_W-1:0]   out_data_next;
    logic [OUT_USER_W-1:0]   out_user_next;

    always_comb
    begin
        fax = p5_fax_reg[FA_W-1:FRAC_BITS];
        fay = p5_fay_reg[FA_W-1:FRAC_BITS];
        fbx = -(FB_W'(fax));
        fby = -(FB_W'(fay));
        sax = (fax[FAF_W-1:POS_W-1] != {(FAF_W-POS_W+1){fax[POS_W-1]}});
        say = (fay[FAF_W-1:POS_W-1] != {(FAF_W-POS_W+1){fay[POS_W-1]}});
        sbx = (fbx[FB_W-1:POS_W-1] != {(FB_W-POS_W+1){fbx[POS_W-1]}});
        sby = (fby[FB_W-1:POS_W-1] != {(FB_W-POS_W+1){fby[POS_W-1]}});
        cax = sax ? (fax[FAF_W-1] ? NEG_MAX : POS_MAX) : fax[POS_W-1:0];
        cay = say ? (fay[FAF_W-1] ? NEG_MAX : POS_MAX) : fay[POS_W-1:0];
        cbx = sbx ? (fbx[FB_W-1] ? NEG_MAX : POS_MAX) : fbx[POS_W-1:0];
        cby = sby ? (fby[FB_W-1] ? NEG_MAX : POS_MAX) : fby[POS_W-1:0];
        if (p_zero_reg[4])
        begin
            out_data_next = '0;
            out_user_next = '0;
            out_user_next[USER_ZERO] = 1'b1;
        end
        else if (p_tw_reg[4])
        begin
            out_data_next = {{(2*POS_W){1'b0}}, cay, cax};
            out_user_next = '0;
            out_user_next[USER_SAT] = sax | say;
        end
        else
        begin
            out_data_next = {cby, cbx, cay, cax};
            out_user_next = '0;
            out_user_next[USER_SAT] = sax | say | sbx | sby;
        end
    end

    logic                  out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= p_vld_reg[4];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // ---------------- Assertions ----------------
    // coincident ends leave a zero root
    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld_reg[SQ_N] && sq_side_reg[SQ_N].zero |-> sq_root_reg[SQ_N] == '0)
        else $error("zero separation with non-zero root");

    // unit vector components never exceed one
    a_unit_x: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[DV_N] && !dv_side_reg[DV_N].zero
        |-> dv_qx_reg[DV_N] <= (Q_W'(1) << FRAC_BITS))
        else $error("unit vector x above one");

    // zero separation result carries no force and no clip
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USER_ZERO]
        |-> m_axis_tdata == '0 && !m_axis_tuser[USER_SAT])
        else $error("zero separation result not cleared");

    // unclipped B force mirrors A
    a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[USER_SAT] && m_axis_tdata[95:64] != '0
        |-> m_axis_tdata[95:64] == POS_W'(-m_axis_tdata[31:0]))
        else $error("B force does not mirror A force");

endmodule
